[hw/rtl/irfr_pkg.sv]
`timescale 1ns / 1ps

package irfr_pkg;

  // Register indexes on the write port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_TIMEOUT    = 1'b1;

  // Register reset values
  localparam logic [11:0] THRESHOLD_RESET = 12'd1000;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd480;

  // Request kinds on tuser
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Sample and accumulator widths
  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 13;
  localparam int SUM_W      = 33;
  localparam int COUNT_W    = 20;
  localparam int WAIT_W     = 17;
  localparam int STRENGTH_W = 13;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 13'd4096;

  // Serial divider: one quotient bit per step over the whole dividend
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic tick;       // request is a timer tick with a sample
    logic clr_frame;  // restart frame position
    logic init_byte;  // clear shift register and bit counter
    logic wait_inc;   // count one more tick without start bit
    logic wait_clr;   // clear wait counter
    logic shift_bit;  // take one data bit
    logic emit;       // byte complete, advance frame position
    logic tmo;        // timeout: close the strength average
    logic div_step;   // advance the divider
    logic receiving;  // receiver not idle after this request
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic line_high;
    logic bits_done;
    logic frame_full;
    logic timeout;
    logic cnt_zero;
    logic div_done;
  } st_t;

endpackage

[hw/rtl/irfr_ctrl.sv]
`timescale 1ns / 1ps

module irfr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           req_type,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output irfr_pkg::cmd_t cmd,
  input  irfr_pkg::st_t  st
);
  import irfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_WAIT,
    PH_SKIP,
    PH_DATA
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   busy;
  logic   out_valid;
  logic   accept;
  logic   start_div;

  // Take a request when not dividing and the output slot frees up
  assign s_tready  = !busy && (!out_valid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign start_div = cmd.tmo && !st.cnt_zero;

  // Decode the receive phase for the current request
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.div_step = busy;
    phase_next   = phase;
    if (req_type == REQ_START) begin
      cmd.clr_frame = 1'b1;
      phase_next    = PH_SETUP;
    end else begin
      cmd.tick = 1'b1;
      case (phase)
        PH_SETUP: begin
          if (st.frame_full) begin
            phase_next = PH_IDLE;
          end else begin
            cmd.init_byte = 1'b1;
            phase_next    = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!st.line_high) begin
            cmd.wait_clr = 1'b1;
            phase_next   = PH_SKIP;
          end else if (st.timeout) begin
            cmd.wait_clr  = 1'b1;
            cmd.clr_frame = 1'b1;
            cmd.tmo       = 1'b1;
            phase_next    = PH_SETUP;
          end else begin
            cmd.wait_inc = 1'b1;
          end
        end
        PH_SKIP: begin
          phase_next = PH_DATA;
        end
        PH_DATA: begin
          cmd.shift_bit = 1'b1;
          if (st.bits_done) begin
            cmd.emit   = 1'b1;
            phase_next = PH_SETUP;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        default: begin
          cmd.clr_frame = 1'b1;
          phase_next    = PH_IDLE;
        end
      endcase
    end
    cmd.receiving = (phase_next != PH_IDLE);
    if (!accept) begin
      cmd.tick      = 1'b0;
      cmd.clr_frame = 1'b0;
      cmd.init_byte = 1'b0;
      cmd.wait_inc  = 1'b0;
      cmd.wait_clr  = 1'b0;
      cmd.shift_bit = 1'b0;
      cmd.emit      = 1'b0;
      cmd.tmo       = 1'b0;
    end
  end

  // Hold phase, divider busy flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        busy      <= start_div;
        out_valid <= !start_div;
      end else if (busy && st.div_done) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/irfr_dp.sv]
`timescale 1ns / 1ps

module irfr_dp #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [irfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [irfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [irfr_pkg::SAMPLE_W-1:0]       adc_sample,
  input  irfr_pkg::cmd_t                      cmd,
  output irfr_pkg::st_t                       st,
  output logic                                out_receiving,
  output logic                                out_byte_valid,
  output logic [7:0]                          out_byte_value,
  output logic [3:0]                          out_byte_index,
  output logic                                out_updated,
  output logic [irfr_pkg::STRENGTH_W-1:0]     out_strength
);
  import irfr_pkg::*;

  localparam int FP_W = $clog2(FRAME_BYTES + 1);

  logic [SAMPLE_W-1:0]   light_threshold;
  logic [15:0]           idle_timeout;
  logic [2:0]            bit_count;
  logic [7:0]            shift_byte;
  logic [7:0]            shift_next;
  logic [FP_W-1:0]       frame_pos;
  logic [FP_W+3:0]       frame_pos_wide;
  logic [WAIT_W-1:0]     wait_ticks;
  logic [WAIT_W-1:0]     wait_inc;
  logic [SUM_W-1:0]      level_sum;
  logic [SUM_W-1:0]      sum_next;
  logic [COUNT_W-1:0]    level_count;
  logic [COUNT_W-1:0]    count_next;
  logic [STRENGTH_W-1:0] strength;
  logic                  light;

  // Serial divider state
  logic [COUNT_W-1:0]    div_den;
  logic [COUNT_W-1:0]    div_rem;
  logic [SUM_W-1:0]      div_quo;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [COUNT_W:0]      rem_sh;
  logic [COUNT_W:0]      rem_sub;
  logic                  div_ge;
  logic [SUM_W-1:0]      quo_step;

  // Accumulate light samples, saturating on the count
  always_comb begin
    light      = (adc_sample < light_threshold);
    sum_next   = level_sum;
    count_next = level_count;
    if (cmd.tick && light && (level_count != '1)) begin
      sum_next   = level_sum + SUM_W'(FULL_SCALE - LEVEL_W'(adc_sample));
      count_next = level_count + 1'b1;
    end
  end

  // Shift in one data bit, least significant first
  always_comb begin
    shift_next = shift_byte;
    if (light) begin
      shift_next = shift_byte;
    end else begin
      shift_next[bit_count] = 1'b1;
    end
  end

  assign wait_inc       = wait_ticks + 1'b1;
  assign frame_pos_wide = {4'b0000, frame_pos};

  // One restoring step per cycle
  assign rem_sh   = {div_rem, div_quo[SUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_sub  = rem_sh - {1'b0, div_den};
  assign quo_step = {div_quo[SUM_W-2:0], div_ge};

  always_comb begin
    st            = '0;
    st.line_high  = !light;
    st.bits_done  = (bit_count == 3'd7);
    st.frame_full = (frame_pos >= FP_W'(FRAME_BYTES));
    st.timeout    = (wait_inc > {1'b0, idle_timeout});
    st.cnt_zero   = (level_count == '0);
    st.div_done   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= THRESHOLD_RESET;
      idle_timeout    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIGHT_THRESHOLD: light_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_IDLE_TIMEOUT:    idle_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance receiver and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count   <= '0;
      shift_byte  <= '0;
      frame_pos   <= '0;
      wait_ticks  <= '0;
      level_sum   <= '0;
      level_count <= '0;
      strength    <= '0;
    end else begin
      if (cmd.tmo) begin
        level_sum   <= '0;
        level_count <= '0;
        if (count_next == '0) begin
          strength <= '0;
        end
      end else if (cmd.tick) begin
        level_sum   <= sum_next;
        level_count <= count_next;
      end
      if (cmd.init_byte) begin
        shift_byte <= '0;
        bit_count  <= '0;
      end
      if (cmd.shift_bit) begin
        shift_byte <= shift_next;
        bit_count  <= bit_count + 1'b1;
      end
      if (cmd.wait_clr) begin
        wait_ticks <= '0;
      end else if (cmd.wait_inc) begin
        wait_ticks <= wait_inc;
      end
      if (cmd.clr_frame) begin
        frame_pos <= '0;
      end else if (cmd.emit) begin
        frame_pos <= frame_pos + 1'b1;
      end
      if (cmd.div_step && st.div_done) begin
        strength <= quo_step[STRENGTH_W-1:0];
      end
    end
  end

  // Run the divider: load on timeout, step while busy
  always_ff @(posedge clk) begin
    if (cmd.tmo) begin
      div_den <= count_next;
      div_quo <= sum_next;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_quo <= quo_step;
      div_rem <= div_ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_receiving  <= cmd.receiving;
      out_byte_valid <= cmd.emit;
      out_byte_value <= cmd.emit ? shift_next : 8'd0;
      out_byte_index <= cmd.emit ? frame_pos_wide[3:0] : 4'd0;
      out_updated    <= cmd.tmo;
      out_strength   <= (cmd.tmo && (count_next == '0)) ? '0 : strength;
    end else if (cmd.div_step && st.div_done) begin
      out_strength <= quo_step[STRENGTH_W-1:0];
    end
  end

endmodule

[hw/rtl/ir_serial_frame_receiver_top.sv]
`timescale 1ns / 1ps
// Infrared serial frame receiver, line sampled twice per bit.
// Slave stream: one request per timer tick (tuser = 0, tdata carries the
// 12-bit detector sample) or a frame start (tuser = 1). Master stream: one
// result per request with the received byte, its frame index, the receiver
// status and the published signal strength.
// Write port: index 0 sets the light threshold, index 1 the idle timeout;
// write only while no request is in flight.
// Latency: a result is presented the cycle after its request is taken, so
// one request per cycle is sustained while the master side keeps up and
// no division runs. A request that times out the start-bit wait with light
// samples in the average runs a bit-serial divider over the 33-bit sum;
// that result appears once the divider finishes, and no request is taken
// meanwhile.
// Reset clears the receiver to idle, empties the strength average and
// restores the register defaults (threshold 1000, timeout 480).
// When the master side stalls, the result is held in the output register
// and a new request is taken only in the cycle the held result leaves.
module ir_serial_frame_receiver_top #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,  // [11:0] adc_sample
  input  logic [0:0]                      s_tuser,  // [0] req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] receiving, [8:1] byte_value, [12:9] byte_index, [25:13] signal_strength
  output logic [31:0]                     m_tdata,
  output logic [1:0]                      m_tuser,  // [0] byte_valid, [1] strength_updated
  input  logic                            cfg_we,
  input  logic [irfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [irfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irfr_pkg::*;

  cmd_t                  cmd;
  st_t                   st;
  logic                  out_receiving;
  logic                  out_byte_valid;
  logic [7:0]            out_byte_value;
  logic [3:0]            out_byte_index;
  logic                  out_updated;
  logic [STRENGTH_W-1:0] out_strength;

  irfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser[0]),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

  irfr_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .adc_sample     (s_tdata[SAMPLE_W-1:0]),
    .cmd            (cmd),
    .st             (st),
    .out_receiving  (out_receiving),
    .out_byte_valid (out_byte_valid),
    .out_byte_value (out_byte_value),
    .out_byte_index (out_byte_index),
    .out_updated    (out_updated),
    .out_strength   (out_strength)
  );

  // Pack the result
  assign m_tdata = {6'd0, out_strength, out_byte_index, out_byte_value, out_receiving};
  assign m_tuser = {out_updated, out_byte_valid};

endmodule

[hw/rtl/irfr_checker.sv]
`timescale 1ns / 1ps

module irfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A byte and a strength update never come with the same request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("byte and strength update in one result");

  // A completed byte or a strength update leaves the receiver active
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> m_tdata[0])
    else $error("receiver idle after byte or timeout");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind ir_serial_frame_receiver_top irfr_checker u_irfr_checker (.*);
